>>> hdl/frlc_pkg.sv
package frlc_pkg;

   localparam int RECORD_BYTES_DEF = 4;
   localparam int PAGE_SLOTS_DEF   = 128;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [15:0] HALF_ERASED = 16'hFFFF;

   localparam logic [1:0] OP_SCAN   = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef struct packed {
      logic       busy;
      logic [7:0] crc;
   } crc_stat_type;

   // fold one byte into the CRC, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
      logic [7:0] c;
      c = c_in ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC of an erased record of n bytes
   function automatic logic [7:0] crc8_ones(input int n);
      logic [7:0] c;
      c = CRC_INIT;
      for (int i = 0; i < n; i++) begin
         c = crc8_byte(c, 8'hFF);
      end
      return c;
   endfunction

endpackage

>>> hdl/flash_record_log_crc8.sv
// Append: S_APP_WAIT, S_APP_CRC until the CRC is done, S_DONE; one CRC byte per cycle.
// Read: one slot read, held in S_RD_WAIT, then S_DONE. Unused opcode: S_DONE only.
// Scan: S_SCAN_CHK, S_SCAN_WAIT, S_SCAN_CRC per valid slot walked; CRC is byte-serial.
// A new beat is taken only in S_IDLE, once the last is done; its result may still wait.
// Reset: fill pointer and fill mark clear at once, so every slot reads erased;
// no clearing pass over the slot memory.
module flash_record_log_crc8 #(
   parameter int RECORD_BYTES = frlc_pkg::RECORD_BYTES_DEF,
   parameter int PAGE_SLOTS   = frlc_pkg::PAGE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_record_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [7:0]  rsp_fill_count,
   output logic        rsp_page_erased,
   output logic        rsp_used_default
);

   localparam int REC_BITS    = 8 * RECORD_BYTES;
   localparam int SLOT_BITS   = REC_BITS + 8;
   localparam int AW          = $clog2(PAGE_SLOTS);
   localparam int PW          = $clog2(PAGE_SLOTS + 1);
   localparam int CHECK_HALVES = (RECORD_BYTES + 1) / 2;
   localparam int CHECK_BITS  = 16 * CHECK_HALVES;
   // erased slots past the mark pass the CRC check when this holds
   localparam bit ONES_OK = (frlc_pkg::crc8_ones(RECORD_BYTES) == 8'hFF);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_SCAN_CHK  = 8'b0000_0010,
      S_SCAN_WAIT = 8'b0000_0100,
      S_SCAN_CRC  = 8'b0000_1000,
      S_APP_WAIT  = 8'b0001_0000,
      S_APP_CRC   = 8'b0010_0000,
      S_RD_WAIT   = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [PW-1:0]       idx_ff, idx_in;
   logic [REC_BITS-1:0] rec_ff, rec_in;
   logic [7:0]          stored_ff, stored_in;
   logic                erase_ff, erase_in;
   logic [31:0]         res_read_ff, res_read_in;
   logic                res_erased_ff, res_erased_in;
   logic                res_dflt_ff, res_dflt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_read_ff;
   logic [7:0]  rsp_fill_ff;
   logic        rsp_erased_ff;
   logic        rsp_dflt_ff;
   logic        rsp_load;

   logic                 rd_en, wr_en, mem_erase;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [SLOT_BITS-1:0] rd_data, wr_data;
   logic [PW-1:0]        mark;

   logic                    crc_start;
   logic [REC_BITS-1:0]     crc_data;
   frlc_pkg::crc_stat_type  crc_stat;

   logic [REC_BITS+31:0] new_rec_ext;
   logic [REC_BITS-1:0]  new_rec;
   logic [REC_BITS+31:0] rd_rec_ext;
   logic [PW+7:0]        fill_ext;
   logic                 accept;

   // bytes of the record past byte 3 store as zero; input bits past the record drop
   assign new_rec_ext = {{REC_BITS{1'b0}}, req_record_data};
   assign new_rec     = new_rec_ext[REC_BITS-1:0];
   assign rd_rec_ext  = {32'b0, rd_data[REC_BITS-1:0]};
   assign fill_ext    = {8'b0, ptr_ff};

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign crc_data  = (state_ff == S_IDLE) ? new_rec : rd_data[REC_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      rec_in        = rec_ff;
      stored_in     = stored_ff;
      erase_in      = erase_ff;
      res_read_in   = res_read_ff;
      res_erased_in = res_erased_ff;
      res_dflt_in   = res_dflt_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(ptr_ff);
      wr_en         = 1'b0;
      wr_addr       = AW'(ptr_ff);
      wr_data       = {crc_stat.crc, rec_ff};
      mem_erase     = 1'b0;
      crc_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_read_in   = '0;
               res_erased_in = 1'b0;
               res_dflt_in   = 1'b0;
               unique case (req_opcode)
                  frlc_pkg::OP_SCAN: begin
                     idx_in   = '0;
                     state_in = S_SCAN_CHK;
                  end
                  frlc_pkg::OP_APPEND: begin
                     // CRC of the new record runs while the target slot is read
                     crc_start = 1'b1;
                     rec_in    = new_rec;
                     rd_en     = (ptr_ff < PW'(PAGE_SLOTS));
                     state_in  = S_APP_WAIT;
                  end
                  frlc_pkg::OP_READ: begin
                     if (ptr_ff == '0) begin
                        res_dflt_in = 1'b1;
                        state_in    = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(ptr_ff - PW'(1));
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN_CHK: begin
            if (idx_ff == PW'(PAGE_SLOTS)) begin
               ptr_in   = idx_ff;
               state_in = S_DONE;
            end else if (idx_ff >= mark) begin
               // the rest of the page is erased: all pass or the walk stops here
               ptr_in   = ONES_OK ? PW'(PAGE_SLOTS) : idx_ff;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff);
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            crc_start = 1'b1;
            stored_in = rd_data[SLOT_BITS-1 -: 8];
            state_in  = S_SCAN_CRC;
         end
         S_SCAN_CRC: begin
            if (!crc_stat.busy) begin
               if (crc_stat.crc == stored_ff) begin
                  idx_in   = idx_ff + PW'(1);
                  state_in = S_SCAN_CHK;
               end else begin
                  ptr_in   = idx_ff;
                  state_in = S_DONE;
               end
            end
         end
         S_APP_WAIT: begin
            // erase when the page is full or the target slot holds data
            erase_in = (ptr_ff >= PW'(PAGE_SLOTS)) ||
                       (rd_data[CHECK_BITS-1:0] != {CHECK_HALVES{frlc_pkg::HALF_ERASED}});
            state_in = S_APP_CRC;
         end
         S_APP_CRC: begin
            if (!crc_stat.busy) begin
               wr_en         = 1'b1;
               res_erased_in = erase_ff;
               if (erase_ff) begin
                  mem_erase = 1'b1;
                  wr_addr   = '0;
                  ptr_in    = PW'(1);
               end else begin
                  ptr_in = ptr_ff + PW'(1);
               end
               state_in = S_DONE;
            end
         end
         S_RD_WAIT: begin
            res_read_in = rd_rec_ext[31:0];
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      rec_ff        <= rec_in;
      stored_ff     <= stored_in;
      erase_ff      <= erase_in;
      res_read_ff   <= res_read_in;
      res_erased_ff <= res_erased_in;
      res_dflt_ff   <= res_dflt_in;
      if (rsp_load) begin
         rsp_read_ff   <= res_read_ff;
         rsp_fill_ff   <= fill_ext[7:0];
         rsp_erased_ff <= res_erased_ff;
         rsp_dflt_ff   <= res_dflt_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_read_ff;
   assign rsp_fill_count   = rsp_fill_ff;
   assign rsp_page_erased  = rsp_erased_ff;
   assign rsp_used_default = rsp_dflt_ff;

   frlc_slot_mem #(
      .RECORD_BYTES (RECORD_BYTES),
      .PAGE_SLOTS   (PAGE_SLOTS)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .erase   (mem_erase),
      .mark    (mark)
   );

   frlc_crc #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .data  (crc_data),
      .stat  (crc_stat)
   );

endmodule

>>> hdl/frlc_crc.sv
module frlc_crc #(
   parameter int RECORD_BYTES = frlc_pkg::RECORD_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [8*RECORD_BYTES-1:0] data,
   output frlc_pkg::crc_stat_type    stat
);

   localparam int REC_BITS = 8 * RECORD_BYTES;
   localparam int CW       = $clog2(RECORD_BYTES + 1);

   logic                busy_ff, busy_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [REC_BITS-1:0] sh_ff, sh_in;
   logic [7:0]          crc_ff, crc_in;

   // one record byte per cycle, byte 0 first
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      crc_in  = crc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = data;
         crc_in  = frlc_pkg::CRC_INIT;
      end else if (busy_ff) begin
         crc_in = frlc_pkg::crc8_byte(crc_ff, sh_ff[7:0]);
         sh_in  = sh_ff >> 8;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(RECORD_BYTES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      crc_ff <= crc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.crc  = crc_ff;

endmodule

>>> hdl/frlc_slot_mem.sv
module frlc_slot_mem #(
   parameter int RECORD_BYTES = frlc_pkg::RECORD_BYTES_DEF,
   parameter int PAGE_SLOTS   = frlc_pkg::PAGE_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [$clog2(PAGE_SLOTS)-1:0]   rd_addr,
   output logic [8*RECORD_BYTES+7:0]       rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(PAGE_SLOTS)-1:0]   wr_addr,
   input  logic [8*RECORD_BYTES+7:0]       wr_data,
   input  logic                            erase,
   output logic [$clog2(PAGE_SLOTS+1)-1:0] mark
);

   localparam int SLOT_BITS = 8 * RECORD_BYTES + 8;
   localparam int PW        = $clog2(PAGE_SLOTS + 1);

   logic [SLOT_BITS-1:0] slot_mem_ff [PAGE_SLOTS];
   logic [SLOT_BITS-1:0] q_ff;
   logic                 hit_ff;
   logic [PW-1:0]        mark_ff, mark_in;

   // slots at or above the mark were never written since the last erase or reset
   always_comb begin
      mark_in = mark_ff;
      if (erase) begin
         mark_in = '0;
      end
      if (wr_en && (erase || PW'(wr_addr) >= mark_ff)) begin
         mark_in = PW'(wr_addr) + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= slot_mem_ff[rd_addr];
         hit_ff <= PW'(rd_addr) < mark_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign rd_data = hit_ff ? q_ff : '1;
   assign mark    = mark_ff;

endmodule
